// File: hw/rtl/ptt_pkg.sv
// Shared types, codes and sizes for the periodic timer table.
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KIND_W     = 2;
   localparam int TIME_W     = 32;
   localparam int HANDLE_W   = 4;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 4;

   // Request data: now, delay, period, lifetime, handle, padded to bytes.
   localparam int REQ_FIELDS_W = 4 * TIME_W + HANDLE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   // Response data: slot, fired, expired, padded to bytes.
   localparam int RSP_FIELDS_W = SLOT_OUT_W + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REPORT   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } ptt_state_type;

   typedef struct packed {
      logic load_req;
      logic do_add;
      logic do_remove;
      logic do_report;
      logic do_done;
      logic idx_init;
      logic idx_dec;
   } ptt_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              out_free;
      logic              cur_valid;
      logic              idx_zero;
   } ptt_stat_type;

endpackage

// File: hw/rtl/periodic_timer_table_core.sv
// Top level of the periodic timer table: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Usage:
// A request on the req_ channel carries its kind in req_tuser: add, remove or
// tick. Add stores now, delay, period and lifetime in the lowest free slot and
// answers with the slot or a full status. Remove frees the slot named by handle
// or answers not found. Tick walks the valid slots from the highest down, sends
// one report per valid slot with fired and expired flags, then a tick-done.
// Every response rides on the rsp_ channel with its status in rsp_tuser, and
// rsp_tlast marks the final response of a request.
// Timing: a request is taken in the idle state only. An add or remove is
// captured, passes the execute state, and its response is loaded into the
// output register once it is free. A tick passes the execute state, the scan
// state visits the 16 slots in turn with the single compare unit, and the done
// state loads the tick-done. The controller returns to idle as the final
// response is loaded, so the next request can be taken while it waits.
// A response waits in an output register; when rsp_tready is low the walk
// holds on the next valid slot, and the register keeps its contents.
// Reset clears all slots to free and empties the output register; slot
// contents are written by add and need no clearing.

module periodic_timer_table_core import ptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now[31:0], delay_ticks[63:32], period_ticks[95:64], lifetime_ticks[127:96],
   // handle[131:128], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot[3:0], fired[4], expired[5], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   ptt_cmd_type           cmd;
   ptt_stat_type          stat;
   logic [SLOT_OUT_W-1:0] out_slot;
   logic                  out_fired;
   logic                  out_expired;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_kind     (req_tuser),
      .in_now      (req_tdata[TIME_W-1:0]),
      .in_delay    (req_tdata[2*TIME_W-1:TIME_W]),
      .in_period   (req_tdata[3*TIME_W-1:2*TIME_W]),
      .in_lifetime (req_tdata[4*TIME_W-1:3*TIME_W]),
      .in_handle   (req_tdata[4*TIME_W+HANDLE_W-1:4*TIME_W]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (rsp_tuser),
      .out_slot    (out_slot),
      .out_fired   (out_fired),
      .out_expired (out_expired),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({out_expired, out_fired, out_slot});

endmodule

// File: hw/rtl/ptt_ctrl.sv
// Controller state machine that sequences add, remove and tick requests.
`timescale 1ns / 1ps

module ptt_ctrl import ptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ptt_stat_type stat,
   output ptt_cmd_type  cmd
);

   ptt_state_type state_ff;
   ptt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.kind)
               KIND_ADD, KIND_REMOVE: begin
                  if (stat.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               KIND_TICK: state_in = ST_SCAN;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_SCAN: begin
            // A free slot is skipped at once; a valid one waits for the output.
            if ((!stat.cur_valid || stat.out_free) && stat.idx_zero) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            case (stat.kind)
               KIND_ADD:    cmd.do_add    = stat.out_free;
               KIND_REMOVE: cmd.do_remove = stat.out_free;
               KIND_TICK:   cmd.idx_init  = 1'b1;
               default:     cmd           = '0;
            endcase
         end
         ST_SCAN: begin
            cmd.do_report = stat.cur_valid && stat.out_free;
            cmd.idx_dec   = (!stat.cur_valid || stat.out_free) && !stat.idx_zero;
         end
         ST_DONE: begin
            cmd.do_done = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// File: hw/rtl/ptt_datapath.sv
// Slot storage, firing and expiry compare, and the registered response stage.
`timescale 1ns / 1ps

module ptt_datapath import ptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_cmd_type           cmd,
   output ptt_stat_type          stat,
   input  logic [KIND_W-1:0]     in_kind,
   input  logic [TIME_W-1:0]     in_now,
   input  logic [TIME_W-1:0]     in_delay,
   input  logic [TIME_W-1:0]     in_period,
   input  logic [TIME_W-1:0]     in_lifetime,
   input  logic [HANDLE_W-1:0]   in_handle,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [STATUS_W-1:0]   out_status,
   output logic [SLOT_OUT_W-1:0] out_slot,
   output logic                  out_fired,
   output logic                  out_expired,
   output logic                  out_last
);

   // Captured request.
   logic [KIND_W-1:0]   kind_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   delay_ff;
   logic [TIME_W-1:0]   period_ff;
   logic [TIME_W-1:0]   lifetime_ff;
   logic [HANDLE_W-1:0] handle_ff;

   // Slot table.
   logic [SLOTS-1:0]  valid_ff;
   logic [SLOTS-1:0]  valid_in;
   logic [TIME_W-1:0] start_mem  [SLOTS];
   logic [TIME_W-1:0] delay_mem  [SLOTS];
   logic [TIME_W-1:0] period_mem [SLOTS];
   logic [TIME_W-1:0] life_mem   [SLOTS];
   logic [TIME_W-1:0] pulse_mem  [SLOTS];

   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic                  fired_ff;
   logic                  expired_ff;
   logic                  last_ff;

   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] rm_idx;
   logic              rm_hit;
   logic [TIME_W-1:0] age;
   logic [TIME_W-1:0] since_pulse;
   logic              fire;
   logic              expire;
   logic              emit;

   // Lowest free slot for an add.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign rm_idx = SLOT_W'(handle_ff);
   assign rm_hit = (int'(handle_ff) < SLOTS) && valid_ff[rm_idx];

   assign age         = now_ff - start_mem[idx_ff];
   assign since_pulse = now_ff - pulse_mem[idx_ff];
   assign fire        = (age > delay_mem[idx_ff])
                        && ((period_mem[idx_ff] == '0) || (since_pulse > period_mem[idx_ff]));
   assign expire      = (life_mem[idx_ff] != '0) && (age > life_mem[idx_ff]);

   assign emit = cmd.do_add || cmd.do_remove || cmd.do_report || cmd.do_done;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.do_add && free_found) begin
         valid_in[free_idx] = 1'b1;
      end
      if (cmd.do_remove && rm_hit) begin
         valid_in[rm_idx] = 1'b0;
      end
      if (cmd.do_report && expire) begin
         valid_in[idx_ff] = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         idx_in = SLOT_W'(SLOTS - 1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         kind_ff     <= in_kind;
         now_ff      <= in_now;
         delay_ff    <= in_delay;
         period_ff   <= in_period;
         lifetime_ff <= in_lifetime;
         handle_ff   <= in_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_add && free_found) begin
         start_mem[free_idx]  <= now_ff;
         delay_mem[free_idx]  <= delay_ff;
         period_mem[free_idx] <= period_ff;
         life_mem[free_idx]   <= lifetime_ff;
         pulse_mem[free_idx]  <= '0;
      end else if (cmd.do_report && fire) begin
         pulse_mem[idx_ff] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         fired_ff   <= cmd.do_report && fire;
         expired_ff <= cmd.do_report && expire;
         last_ff    <= !cmd.do_report;
         if (cmd.do_add) begin
            status_ff <= free_found ? STATUS_ADDED : STATUS_FULL;
            slot_ff   <= free_found ? SLOT_OUT_W'(free_idx) : '0;
         end else if (cmd.do_remove) begin
            status_ff <= rm_hit ? STATUS_REMOVED : STATUS_NOTFOUND;
            slot_ff   <= SLOT_OUT_W'(handle_ff);
         end else if (cmd.do_report) begin
            status_ff <= STATUS_REPORT;
            slot_ff   <= SLOT_OUT_W'(idx_ff);
         end else begin
            status_ff <= STATUS_DONE;
            slot_ff   <= '0;
         end
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.out_free  = !rsp_valid_ff || out_ready;
   assign stat.cur_valid = valid_ff[idx_ff];
   assign stat.idx_zero  = (idx_ff == '0);

   assign out_valid   = rsp_valid_ff;
   assign out_status  = status_ff;
   assign out_slot    = slot_ff;
   assign out_fired   = fired_ff;
   assign out_expired = expired_ff;
   assign out_last    = last_ff;

endmodule

// File: hw/rtl/ptt_check.sv
// Port-level assertions for the periodic timer table, bound to the top level.
`timescale 1ns / 1ps

module ptt_check import ptt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [KIND_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  rsp_tlast
);

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // One request at a time: the block is busy right after taking a request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Only slot reports leave the request open; every other response closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != STATUS_REPORT)))
      else $error("response last flag does not match its status");

   // Fired and expired flags appear on slot reports alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_REPORT |-> rsp_tdata[SLOT_OUT_W+1:SLOT_OUT_W] == 2'b00)
      else $error("flags set outside a slot report");

   // Tick-done and table-full carry slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_DONE || rsp_tuser == STATUS_FULL)
         |-> rsp_tdata[SLOT_OUT_W-1:0] == '0)
      else $error("nonzero slot on tick-done or table-full");

endmodule

bind periodic_timer_table_core ptt_check u_ptt_check (.*);
